@@ src/flm_pkg.sv @@
// Shared types, character codes and sizes for the float literal matcher.
`default_nettype none
package flm_pkg;

   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam int MATCH_LENGTH_BITS   = 16;
   localparam int CSR_INDEX_BITS      = 1;
   localparam int CSR_DATA_BITS       = 2;
   localparam int QUEUE_DEPTH         = 4;
   localparam int QUEUE_PTR_BITS      = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIGN_MODE      = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALLOW_EXPONENT = 1'd1;

   localparam logic [1:0] SIGN_NONE      = 2'd0;
   localparam logic [1:0] SIGN_PLUS_MINUS = 2'd2;
   localparam logic [1:0] SIGN_MODE_RESET = 2'd1;

   localparam logic [7:0] CHAR_CASE_BIT = 8'h20;
   localparam logic [7:0] CHAR_LOWER_E  = 8'h65;
   localparam logic [7:0] CHAR_DOT      = 8'h2e;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;
   localparam logic [7:0] CHAR_MINUS    = 8'h2d;
   localparam logic [7:0] CHAR_PLUS     = 8'h2b;

   typedef enum logic [2:0] {
      CLS_ZERO,
      CLS_DIGIT,
      CLS_DOT,
      CLS_MINUS,
      CLS_PLUS,
      CLS_EXP,
      CLS_OTHER
   } char_class_type;

   typedef enum logic [2:0] {
      PH_START,
      PH_INT,
      PH_FRAC,
      PH_EXP_MARK,
      PH_EXP_SIGN,
      PH_EXP_DIGITS
   } phase_type;

   typedef struct packed {
      char_class_type cls;
      logic           is_final;
      logic           empty_source;
   } q_entry_type;

   typedef struct packed {
      logic        valid;
      q_entry_type entry;
   } q_head_type;

   typedef struct packed {
      logic [1:0] sign_mode;
      logic       allow_exponent;
   } cfg_type;

endpackage
`default_nettype wire

@@ src/flm_front.sv @@
// Front end: classifies each request byte and queues it for the scanner.
`default_nettype none
module flm_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [7:0]          req_char_byte,
   input  wire logic                req_is_final,
   input  wire logic                req_empty_source,
   output flm_pkg::q_head_type      head,
   input  wire logic                pop
);
   import flm_pkg::*;

   q_entry_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   q_entry_type               entry;
   logic                      push;
   logic                      do_pop;

   always_comb begin
      if (req_char_byte == CHAR_ZERO) begin
         entry.cls = CLS_ZERO;
      end else if (req_char_byte > CHAR_ZERO && req_char_byte <= CHAR_NINE) begin
         entry.cls = CLS_DIGIT;
      end else if (req_char_byte == CHAR_DOT) begin
         entry.cls = CLS_DOT;
      end else if (req_char_byte == CHAR_MINUS) begin
         entry.cls = CLS_MINUS;
      end else if (req_char_byte == CHAR_PLUS) begin
         entry.cls = CLS_PLUS;
      end else if ((req_char_byte | CHAR_CASE_BIT) == CHAR_LOWER_E) begin
         entry.cls = CLS_EXP;
      end else begin
         entry.cls = CLS_OTHER;
      end
      entry.is_final     = req_is_final;
      entry.empty_source = req_empty_source;
   end

   assign req_ready = (count_ff != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign do_pop    = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + (QUEUE_PTR_BITS+1)'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - (QUEUE_PTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule
`default_nettype wire

@@ src/flm_back.sv @@
// Back end: literal scanner state machine and the result register.
`default_nettype none
module flm_back #(
   parameter int LENGTH_BITS = flm_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire flm_pkg::q_head_type                   head,
   output logic                                       pop,
   input  wire flm_pkg::cfg_type                      cfg,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [flm_pkg::MATCH_LENGTH_BITS-1:0]      rsp_match_length,
   output logic                                       rsp_length_saturated
);
   import flm_pkg::*;

   // counter stops at the smaller of the parameter range and the port range
   localparam int POS_BITS = (LENGTH_BITS > MATCH_LENGTH_BITS) ? MATCH_LENGTH_BITS
                                                              : LENGTH_BITS;

   phase_type             phase_ff, phase_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic                  fzero_ff, fzero_in;
   logic                  dot_ff, dot_in;
   logic                  decided_ff, decided_in;
   logic                  sat_ff, sat_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [MATCH_LENGTH_BITS-1:0]  rsp_len_ff, rsp_len_in;
   logic                          rsp_sat_ff, rsp_sat_in;

   char_class_type cls;
   phase_type      eff;
   logic           fin, emp, is_dig, sign_take;
   logic           do_acc, mant_end, emit, ok;
   logic           slot_free;
   logic [POS_BITS-1:0] pos_res;
   logic           sat_res;

   assign cls       = head.entry.cls;
   assign fin       = head.entry.is_final;
   assign emp       = head.entry.empty_source;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      cnt_in     = cnt_ff;
      fzero_in   = fzero_ff;
      dot_in     = dot_ff;
      decided_in = decided_ff;
      sat_in     = sat_ff;
      do_acc     = 1'b0;
      mant_end   = 1'b0;
      emit       = 1'b0;
      ok         = 1'b0;
      is_dig     = (cls == CLS_ZERO) || (cls == CLS_DIGIT);
      sign_take  = (phase_ff == PH_START) && (cfg.sign_mode != SIGN_NONE) &&
                   ((cls == CLS_MINUS) ||
                    (cfg.sign_mode == SIGN_PLUS_MINUS && cls == CLS_PLUS));
      eff        = (phase_ff == PH_START) ? PH_INT : phase_ff;

      if (!decided_ff && !(fin && emp)) begin
         if (sign_take) begin
            do_acc   = 1'b1;
            phase_in = PH_INT;
         end else begin
            phase_in = eff;
            case (eff)
               PH_INT: begin
                  if (is_dig) begin
                     if (cnt_ff != 2'd0 && fzero_ff) begin
                        emit = 1'b1;   // leading zero followed by a digit
                     end else begin
                        if (cnt_ff == 2'd0) begin
                           fzero_in = (cls == CLS_ZERO);
                        end
                        if (cnt_ff != 2'd2) begin
                           cnt_in = cnt_ff + 2'd1;
                        end
                        do_acc = 1'b1;
                     end
                  end else if (cls == CLS_DOT) begin
                     dot_in   = 1'b1;
                     do_acc   = 1'b1;
                     phase_in = PH_FRAC;
                  end else if (cnt_ff == 2'd0) begin
                     emit = 1'b1;
                  end else begin
                     mant_end = 1'b1;
                  end
               end
               PH_FRAC: begin
                  if (is_dig) begin
                     do_acc = 1'b1;
                  end else begin
                     mant_end = 1'b1;
                  end
               end
               PH_EXP_MARK: begin
                  if (cls == CLS_PLUS || cls == CLS_MINUS) begin
                     do_acc   = 1'b1;
                     phase_in = PH_EXP_SIGN;
                  end else if (is_dig) begin
                     do_acc   = 1'b1;
                     phase_in = PH_EXP_DIGITS;
                  end else begin
                     emit = 1'b1;
                  end
               end
               PH_EXP_SIGN: begin
                  if (is_dig) begin
                     do_acc   = 1'b1;
                     phase_in = PH_EXP_DIGITS;
                  end else begin
                     emit = 1'b1;
                  end
               end
               PH_EXP_DIGITS: begin
                  if (is_dig) begin
                     do_acc = 1'b1;
                  end else begin
                     emit = 1'b1;
                     ok   = 1'b1;
                  end
               end
               default: begin
                  emit = 1'b1;
               end
            endcase
            if (mant_end) begin
               if (cfg.allow_exponent && cls == CLS_EXP) begin
                  do_acc   = 1'b1;
                  phase_in = PH_EXP_MARK;
               end else begin
                  emit = 1'b1;
                  ok   = 1'b1;
               end
            end
         end
      end

      if (do_acc) begin
         if (pos_ff == '1) begin
            sat_in = 1'b1;
         end else begin
            pos_in = pos_ff + POS_BITS'(1);
         end
      end

      // length and flag as they stand before the source is cleared
      pos_res = pos_in;
      sat_res = sat_in;

      // end of source closes whatever is still open
      if (!decided_ff && !emit && fin) begin
         emit = 1'b1;
         case (phase_in)
            PH_INT:                 ok = (cnt_in != 2'd0) || dot_in;
            PH_FRAC, PH_EXP_DIGITS: ok = 1'b1;
            default:                ok = 1'b0;
         endcase
      end

      if (emit) begin
         decided_in = 1'b1;
      end

      if (fin) begin
         phase_in   = PH_START;
         pos_in     = '0;
         cnt_in     = 2'd0;
         fzero_in   = 1'b0;
         dot_in     = 1'b0;
         decided_in = 1'b0;
         sat_in     = 1'b0;
      end
   end

   assign pop = head.valid && (!emit || slot_free);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_len_in   = rsp_len_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
         rsp_len_in   = ok ? MATCH_LENGTH_BITS'(pos_res) : '0;
         rsp_sat_in   = ok && sat_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         pos_ff       <= '0;
         cnt_ff       <= 2'd0;
         fzero_ff     <= 1'b0;
         dot_ff       <= 1'b0;
         decided_ff   <= 1'b0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff   <= phase_in;
            pos_ff     <= pos_in;
            cnt_ff     <= cnt_in;
            fzero_ff   <= fzero_in;
            dot_ff     <= dot_in;
            decided_ff <= decided_in;
            sat_ff     <= sat_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_len_ff <= rsp_len_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_match_length     = rsp_len_ff;
   assign rsp_length_saturated = rsp_sat_ff;

endmodule
`default_nettype wire

@@ src/float_literal_matcher.sv @@
// Top level of the float literal matcher: CSR block, front end and scanner.
// Streams one source byte per request and returns, once per source, the
// length of the floating-point literal at its start (0 when there is none).
// The front end classifies each byte and writes it into a four-entry queue;
// the scanner takes one queued request per cycle while no result waits on
// rsp_ready, so the block then sustains one request per clock. A deciding
// request passes through the queue and then the output register before
// rsp_valid rises. The result sits in an output register; the queue
// keeps taking requests while that register waits for rsp_ready. Requests
// after the decision are swallowed up to the one with is_final. Lengths stop
// at 2^LENGTH_BITS-1 (at most 65535) with rsp_length_saturated set.
// CSR writes are always ready and should be made only while idle.
`default_nettype none
module float_literal_matcher #(
   parameter int LENGTH_BITS = flm_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [7:0]                            req_char_byte,
   input  wire logic                                  req_is_final,
   input  wire logic                                  req_empty_source,
   // result channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [flm_pkg::MATCH_LENGTH_BITS-1:0]      rsp_match_length,
   output logic                                       rsp_length_saturated,
   // CSR write channel
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [flm_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [flm_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import flm_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   q_head_type head;
   logic       pop;

   assign csr_ready = 1'b1;

   // register 0 is the sign policy, register 1 the exponent enable
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SIGN_MODE:      cfg_in.sign_mode      = csr_data;
            CSR_ALLOW_EXPONENT: cfg_in.allow_exponent = csr_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sign_mode      <= SIGN_MODE_RESET;
         cfg_ff.allow_exponent <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   flm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_byte    (req_char_byte),
      .req_is_final     (req_is_final),
      .req_empty_source (req_empty_source),
      .head             (head),
      .pop              (pop)
   );

   flm_back #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head),
      .pop                  (pop),
      .cfg                  (cfg_ff),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_match_length     (rsp_match_length),
      .rsp_length_saturated (rsp_length_saturated)
   );

endmodule
`default_nettype wire
